// ===== design/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// Stuffed frame receiver package
// Shared widths, byte codes, event codes, register indexes and bundle types.
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam int BYTE_W  = 8;
    localparam int EV_W    = 3;
    localparam int LEN_W   = 10;
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 4;

    localparam int MAX_DATA_BYTES_DEF = 512;

    // Line byte codes
    localparam logic [BYTE_W-1:0] ESC_BYTE = 8'h7D;
    localparam logic [BYTE_W-1:0] FLAG_BYTE = 8'h7E;
    localparam logic [BYTE_W-1:0] ESC_FLAG = 8'h5E;
    localparam logic [BYTE_W-1:0] ESC_ESC = 8'h5D;

    // Result event codes
    localparam logic [EV_W-1:0] EV_DATA     = 3'd0;
    localparam logic [EV_W-1:0] EV_SUPER    = 3'd1;
    localparam logic [EV_W-1:0] EV_INFO_OK  = 3'd2;
    localparam logic [EV_W-1:0] EV_HEAD_BAD = 3'd3;
    localparam logic [EV_W-1:0] EV_DATA_BAD = 3'd4;

    // Register indexes (byte address is four times the index)
    localparam logic [1:0] REG_MATCH_ADDR = 2'd0;
    localparam logic [1:0] REG_ADDR_ANY   = 2'd1;
    localparam logic [1:0] REG_MATCH_CTRL = 2'd2;
    localparam logic [1:0] REG_CTRL_ANY   = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] match_address;
        logic              address_any;
        logic [BYTE_W-1:0] match_control;
        logic              control_any;
    } t_cfg;

    // One destuffed byte and whether it is a real (unescaped) flag
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              flag;
    } t_beat;

endpackage

// ===== design/sfr_if.sv =====
// ----------------------------------------------------------------------------
// Stuffed frame receiver channel interfaces
// Valid/ready channels for received line bytes and for frame results.
// ----------------------------------------------------------------------------
interface sfr_rx_if;
    logic                      valid;
    logic                      ready;
    logic [sfr_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfr_res_if;
    logic                       valid;
    logic                       ready;
    logic [sfr_pkg::EV_W-1:0]   event_res;
    logic [sfr_pkg::BYTE_W-1:0] data_byte;
    logic [sfr_pkg::BYTE_W-1:0] frame_address;
    logic [sfr_pkg::BYTE_W-1:0] frame_control;
    logic [sfr_pkg::LEN_W-1:0]  data_length;

    modport source (output valid, output event_res, output data_byte,
                    output frame_address, output frame_control,
                    output data_length, input ready);
    modport sink (input valid, input event_res, input data_byte,
                  input frame_address, input frame_control,
                  input data_length, output ready);
endinterface

// ===== design/stuffed_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// Stuffed frame receiver
// Destuffs received line bytes, checks frame headers and BCCs, emits results.
// ----------------------------------------------------------------------------
// Path: a line byte passes the destuffing register, then the framing state
// machine into the result register; payload bytes come out one byte late.
// Throughput: one line byte per cycle unless a waiting result stalls it, set
// by the single destuffing register and the framing state machine.
// Reset: synchronous, active low; clears the framing state, escape tracking
// and valid flags, and returns the registers to any address / any control.
//
// Structure: sfr_destuff is the input register. It drops raw escape bytes,
// restores escaped flag and escape bytes and tags only unescaped 0x7E bytes
// as flags, so an escaped flag is always data. sfr_frame walks the address,
// control and BCC1 slots, then holds each payload byte back by one beat so
// that the byte before the closing flag can be checked as BCC2 against the
// running XOR rather than emitted. Its result register holds each result
// until taken, and no new beat is taken while it waits. sfr_cfg is the
// register file, to be written by the user only while idle; it does not enforce it.
module stuffed_frame_receiver #(
    parameter int MAX_DATA_BYTES = sfr_pkg::MAX_DATA_BYTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    sfr_rx_if.sink                      i_rx,
    sfr_res_if.source                   o_res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sfr_pkg::APB_AW-1:0]  paddr,
    input  logic [sfr_pkg::APB_DW-1:0]  pwdata,
    output logic [sfr_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);

    sfr_pkg::t_cfg  cfg;
    sfr_pkg::t_beat beat;
    logic           beat_valid;
    logic           beat_take;

    sfr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    sfr_destuff u_destuff (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_take  (beat_take),
        .o_valid (beat_valid),
        .o_beat  (beat)
    );

    sfr_frame #(
        .MAX_DATA_BYTES (MAX_DATA_BYTES)
    ) u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (beat_valid),
        .i_beat  (beat),
        .o_take  (beat_take),
        .o_res   (o_res)
    );

endmodule

// ===== design/sfr_cfg.sv =====
// ----------------------------------------------------------------------------
// Stuffed frame receiver configuration registers
// APB-style register file holding the address and control match settings.
// ----------------------------------------------------------------------------
module sfr_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sfr_pkg::APB_AW-1:0]  paddr,
    input  logic [sfr_pkg::APB_DW-1:0]  pwdata,
    output logic [sfr_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output sfr_pkg::t_cfg               o_cfg
);

    sfr_pkg::t_cfg r_cfg;
    logic          wr_en;
    logic [1:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.match_address <= '0;
            r_cfg.address_any   <= 1'b1;
            r_cfg.match_control <= '0;
            r_cfg.control_any   <= 1'b1;
        end else if (wr_en) begin
            case (reg_idx)
                sfr_pkg::REG_MATCH_ADDR: r_cfg.match_address <= pwdata[7:0];
                sfr_pkg::REG_ADDR_ANY:   r_cfg.address_any   <= pwdata[0];
                sfr_pkg::REG_MATCH_CTRL: r_cfg.match_control <= pwdata[7:0];
                sfr_pkg::REG_CTRL_ANY:   r_cfg.control_any   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            sfr_pkg::REG_MATCH_ADDR: prdata = {24'd0, r_cfg.match_address};
            sfr_pkg::REG_ADDR_ANY:   prdata = {31'd0, r_cfg.address_any};
            sfr_pkg::REG_MATCH_CTRL: prdata = {24'd0, r_cfg.match_control};
            sfr_pkg::REG_CTRL_ANY:   prdata = {31'd0, r_cfg.control_any};
            default:                 prdata = '0;
        endcase
    end

endmodule

// ===== design/sfr_destuff.sv =====
// ----------------------------------------------------------------------------
// Stuffed frame receiver destuffing stage
// Input register that removes escape bytes and marks unescaped flags.
// ----------------------------------------------------------------------------
module sfr_destuff (
    input  logic           i_clk,
    input  logic           i_rst_n,
    sfr_rx_if.sink         i_rx,
    input  logic           i_take,
    output logic           o_valid,
    output sfr_pkg::t_beat o_beat
);

    logic           r_esc;
    logic           r_valid;
    sfr_pkg::t_beat r_beat;
    logic           accept;
    logic           is_esc;
    sfr_pkg::t_beat n_beat;

    assign i_rx.ready = !r_valid || i_take;
    assign accept     = i_rx.valid && i_rx.ready;
    // A raw escape byte only arms the escape; it makes no beat.
    assign is_esc     = !r_esc && (i_rx.rx_byte == sfr_pkg::ESC_BYTE);

    always_comb begin
        n_beat.data = i_rx.rx_byte;
        n_beat.flag = 1'b0;
        if (r_esc) begin
            if (i_rx.rx_byte == sfr_pkg::ESC_FLAG) begin
                n_beat.data = sfr_pkg::FLAG_BYTE;
            end else if (i_rx.rx_byte == sfr_pkg::ESC_ESC) begin
                n_beat.data = sfr_pkg::ESC_BYTE;
            end
        end else begin
            n_beat.flag = (i_rx.rx_byte == sfr_pkg::FLAG_BYTE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_esc <= is_esc;
            end
            if (accept && !is_esc) begin
                r_valid <= 1'b1;
            end else if (i_take) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !is_esc) begin
            r_beat <= n_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

// ===== design/sfr_frame.sv =====
// ----------------------------------------------------------------------------
// Stuffed frame receiver framing engine
// Header checks, delayed data emission, BCC2 check and result register.
// ----------------------------------------------------------------------------
module sfr_frame #(
    parameter int MAX_DATA_BYTES = sfr_pkg::MAX_DATA_BYTES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sfr_pkg::t_cfg  i_cfg,
    input  logic           i_valid,
    input  sfr_pkg::t_beat i_beat,
    output logic           o_take,
    sfr_res_if.source      o_res
);

    localparam int RAW_W = $clog2(MAX_DATA_BYTES + 1);
    localparam int CNT_W = (RAW_W > sfr_pkg::LEN_W) ? RAW_W : sfr_pkg::LEN_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DATA_BYTES);

    localparam logic [2:0] ST_HUNT    = 3'd0;
    localparam logic [2:0] ST_ADDR    = 3'd1;
    localparam logic [2:0] ST_CTRL    = 3'd2;
    localparam logic [2:0] ST_BCC1    = 3'd3;
    localparam logic [2:0] ST_HEAD_OK = 3'd4;
    localparam logic [2:0] ST_DATA    = 3'd5;
    localparam logic [2:0] ST_BCC2    = 3'd6;

    logic [2:0]                 r_state, n_state;
    logic [sfr_pkg::BYTE_W-1:0] r_addr, n_addr;
    logic [sfr_pkg::BYTE_W-1:0] r_ctrl, n_ctrl;
    logic [sfr_pkg::BYTE_W-1:0] r_xor, n_xor;
    logic [sfr_pkg::BYTE_W-1:0] r_held, n_held;
    logic [CNT_W-1:0]           r_count, n_count;

    logic                       r_res_valid;
    logic [sfr_pkg::EV_W-1:0]   r_ev;
    logic [sfr_pkg::BYTE_W-1:0] r_data;
    logic [sfr_pkg::BYTE_W-1:0] r_fa;
    logic [sfr_pkg::BYTE_W-1:0] r_fc;
    logic [sfr_pkg::LEN_W-1:0]  r_len;

    logic                       emit;
    logic [sfr_pkg::EV_W-1:0]   ev;
    logic [sfr_pkg::BYTE_W-1:0] ev_data;
    logic [CNT_W-1:0]           ev_len;
    logic [CNT_W-1:0]           cnt_inc;
    logic                       flag;
    logic [sfr_pkg::BYTE_W-1:0] b;
    logic                       closing;

    assign o_take  = i_valid && (!r_res_valid || o_res.ready);
    assign flag    = i_beat.flag;
    assign b       = i_beat.data;
    assign cnt_inc = r_count + CNT_W'(1);
    // Closing flag in a data frame: reported before the frame state clears.
    assign closing = flag && (r_state == ST_DATA || r_state == ST_BCC2);

    always_comb begin
        n_state = r_state;
        n_addr  = r_addr;
        n_ctrl  = r_ctrl;
        n_xor   = r_xor;
        n_held  = r_held;
        n_count = r_count;
        emit    = 1'b0;
        ev      = sfr_pkg::EV_HEAD_BAD;
        ev_data = '0;
        ev_len  = '0;
        case (r_state)
            ST_ADDR: begin
                if (!flag) begin
                    n_addr = b;
                    if (i_cfg.address_any || b == i_cfg.match_address) begin
                        n_state = ST_CTRL;
                    end else begin
                        n_state = ST_HUNT;
                        emit    = 1'b1;
                    end
                end
            end
            ST_CTRL: begin
                if (!flag) begin
                    n_ctrl = b;
                end
                if (!flag && (i_cfg.control_any || b == i_cfg.match_control)) begin
                    n_state = ST_BCC1;
                end else begin
                    n_state = flag ? ST_ADDR : ST_HUNT;
                    emit    = 1'b1;
                end
            end
            ST_BCC1: begin
                if (!flag && b == (r_addr ^ r_ctrl)) begin
                    n_state = ST_HEAD_OK;
                end else begin
                    n_state = flag ? ST_ADDR : ST_HUNT;
                    emit    = 1'b1;
                end
            end
            ST_HEAD_OK: begin
                if (flag) begin
                    n_state = ST_ADDR;
                    emit    = 1'b1;
                    ev      = sfr_pkg::EV_SUPER;
                end else begin
                    n_xor   = '0;
                    n_count = '0;
                    n_held  = b;
                    n_state = ST_DATA;
                end
            end
            ST_DATA, ST_BCC2: begin
                emit = 1'b1;
                if (flag) begin
                    ev      = (r_held == r_xor) ? sfr_pkg::EV_INFO_OK
                                                : sfr_pkg::EV_DATA_BAD;
                    ev_len  = r_count;
                    n_state = ST_ADDR;
                end else if (r_state == ST_DATA) begin
                    ev      = sfr_pkg::EV_DATA;
                    ev_data = r_held;
                    n_xor   = r_xor ^ r_held;
                    n_count = cnt_inc;
                    ev_len  = cnt_inc;
                    n_held  = b;
                    if (cnt_inc >= CNT_MAX) begin
                        n_state = ST_BCC2;
                    end
                end else begin
                    // Anything but a flag after BCC2 is an overlong frame.
                    ev      = sfr_pkg::EV_DATA_BAD;
                    ev_len  = r_count;
                    n_state = ST_HUNT;
                end
            end
            default: begin
                n_state = flag ? ST_ADDR : ST_HUNT;
            end
        endcase
        // Every return to hunting or to the address slot clears the frame.
        if ((n_state == ST_HUNT || n_state == ST_ADDR) && r_state != ST_ADDR) begin
            n_xor   = '0;
            n_count = '0;
            n_held  = '0;
        end
        if (closing) begin
            n_xor   = '0;
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_HUNT;
            r_addr      <= '0;
            r_ctrl      <= '0;
            r_xor       <= '0;
            r_held      <= '0;
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_state <= n_state;
                r_addr  <= n_addr;
                r_ctrl  <= n_ctrl;
                r_xor   <= n_xor;
                r_held  <= n_held;
                r_count <= n_count;
            end
            if (o_take && emit) begin
                r_res_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && emit) begin
            r_ev   <= ev;
            r_data <= ev_data;
            r_fa   <= n_addr;
            r_fc   <= n_ctrl;
            r_len  <= ev_len[sfr_pkg::LEN_W-1:0];
        end
    end

    assign o_res.valid         = r_res_valid;
    assign o_res.event_res     = r_ev;
    assign o_res.data_byte     = r_data;
    assign o_res.frame_address = r_fa;
    assign o_res.frame_control = r_fc;
    assign o_res.data_length   = r_len;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("payload count ran past the frame limit");

    a_count_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_DATA && r_state != ST_BCC2) |-> r_count == '0)
        else $error("payload count not cleared outside the data phase");

    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && r_ev != sfr_pkg::EV_DATA) |-> r_data == '0)
        else $error("data byte set on a non-data event");

    a_super_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && emit && ev == sfr_pkg::EV_SUPER) |=> r_state == ST_ADDR)
        else $error("supervisory frame end did not rearm the address slot");

endmodule

// ===== bench/tb_stuffed_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// Stuffed frame receiver testbench
// Feeds stuffed line bytes through valid/ready channels and checks every
// result beat against an in-bench frame decoder. A short directed table
// covers flags, escapes and header and BCC errors. Maximum-length payloads
// follow, then random frames under several register settings.
// ----------------------------------------------------------------------------
module tb_stuffed_frame_receiver;

    localparam int BYTE_W = sfr_pkg::BYTE_W;
    localparam int EV_W   = sfr_pkg::EV_W;
    localparam int LEN_W  = sfr_pkg::LEN_W;
    localparam int APB_AW = sfr_pkg::APB_AW;
    localparam int APB_DW = sfr_pkg::APB_DW;

    localparam logic [BYTE_W-1:0] ESC_BYTE  = sfr_pkg::ESC_BYTE;
    localparam logic [BYTE_W-1:0] FLAG_BYTE = sfr_pkg::FLAG_BYTE;
    localparam logic [BYTE_W-1:0] ESC_FLAG  = sfr_pkg::ESC_FLAG;
    localparam logic [BYTE_W-1:0] ESC_ESC   = sfr_pkg::ESC_ESC;

    localparam logic [EV_W-1:0] EV_DATA     = sfr_pkg::EV_DATA;
    localparam logic [EV_W-1:0] EV_SUPER    = sfr_pkg::EV_SUPER;
    localparam logic [EV_W-1:0] EV_INFO_OK  = sfr_pkg::EV_INFO_OK;
    localparam logic [EV_W-1:0] EV_HEAD_BAD = sfr_pkg::EV_HEAD_BAD;
    localparam logic [EV_W-1:0] EV_DATA_BAD = sfr_pkg::EV_DATA_BAD;

    localparam logic [1:0] REG_MATCH_ADDR = sfr_pkg::REG_MATCH_ADDR;
    localparam logic [1:0] REG_ADDR_ANY   = sfr_pkg::REG_ADDR_ANY;
    localparam logic [1:0] REG_MATCH_CTRL = sfr_pkg::REG_MATCH_CTRL;
    localparam logic [1:0] REG_CTRL_ANY   = sfr_pkg::REG_CTRL_ANY;

    typedef sfr_pkg::t_cfg t_cfg;

    // The limit leaves a wide margin over the slowest legal run for stalls,
    // the long hold-off and the register phases.
    localparam int CYCLE_LIMIT     = 400000;
    // A result goes through the destuffing and result registers. Escapes and held
    // payload bytes make no result, so give the pipe a little longer to
    // empty before a register write.
    localparam int SETTLE_CYCLES   = 6;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PHASE_ITEMS     = 45;
    localparam int MAX_PAYLOAD     = sfr_pkg::MAX_DATA_BYTES_DEF;

    // Frame decoder phases, in the order a well-formed frame passes them.
    typedef enum logic [3:0] {
        PH_HUNT, PH_ADDR, PH_CTRL, PH_BCC1, PH_HEAD_OK, PH_DATA, PH_BCC2
    } t_frame_phase;

    typedef enum int {
        FR_CLEAN, FR_SUPER, FR_BAD_BCC1, FR_BAD_BCC2, FR_ODD_ESCAPE
    } t_frame_kind;

    typedef struct packed {
        logic [EV_W-1:0]   ev_code;
        logic [BYTE_W-1:0] data;
        logic [BYTE_W-1:0] address;
        logic [BYTE_W-1:0] control;
        logic [LEN_W-1:0]  length;
    } t_frame_result;

    typedef struct packed {
        logic [BYTE_W-1:0] raw;
        logic              checked;
        t_frame_result     want;
    } t_directed_row;

    logic i_clk;
    logic i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    sfr_rx_if  rx_ch ();
    sfr_res_if res_ch ();

    stuffed_frame_receiver uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Decoder state and its copy of the register file. The register copy
    // starts at the reset values: any address, any control.
    t_cfg              cfg = '{8'h00, 1'b1, 8'h00, 1'b1};
    t_frame_phase      phase = PH_HUNT;
    logic              esc_seen = 1'b0;
    logic [BYTE_W-1:0] hdr_addr = 8'h00;
    logic [BYTE_W-1:0] hdr_ctrl = 8'h00;
    logic [BYTE_W-1:0] pay_xor = 8'h00;
    logic [BYTE_W-1:0] held = 8'h00;
    logic              held_ok = 1'b0;
    logic [LEN_W-1:0]  pay_count = '0;

    t_frame_result frame_results_due[$];
    t_directed_row directed_rows[$];
    t_frame_result typed_want;
    logic          typed_pending = 1'b0;
    t_frame_result want;
    t_frame_result got;

    int errors = 0;
    int line_bytes = 0;
    int counted_items = 0;
    int idle_odds = 0;
    int hold_requests = 0;
    int holds_done = 0;
    int cycle_count = 0;
    int ev_tally[5] = '{0, 0, 0, 0, 0};

    logic [1:0] reg_order[4] = '{REG_MATCH_ADDR, REG_ADDR_ANY, REG_MATCH_CTRL, REG_CTRL_ANY};

    // ------------------------------------------------------------------
    // Frame decoder
    // ------------------------------------------------------------------

    // Drop back to hunting, or straight to the address slot when the byte
    // that ended things was itself a flag.
    function automatic void restart_frame(input logic on_flag);
        phase     = on_flag ? PH_ADDR : PH_HUNT;
        held_ok   = 1'b0;
        held      = 8'h00;
        pay_count = '0;
        pay_xor   = 8'h00;
    endfunction

    function automatic t_frame_result frame_result(input logic [EV_W-1:0] ev,
                                                   input logic [BYTE_W-1:0] d);
        t_frame_result r;
        r.ev_code = ev;
        r.data    = d;
        r.address = hdr_addr;
        r.control = hdr_ctrl;
        r.length  = pay_count;
        return r;
    endfunction

    // Takes one raw line byte and returns 1 with the result it causes, if any.
    function automatic logic decode_line_byte(input logic [BYTE_W-1:0] raw,
                                              output t_frame_result r);
        logic [BYTE_W-1:0] b;
        logic              is_flag;
        logic [BYTE_W-1:0] d;
        b = raw;
        r = '0;
        if (esc_seen) begin
            // An escaped byte is always data, even a raw 0x7E.
            esc_seen = 1'b0;
            if (b == ESC_FLAG)
                b = FLAG_BYTE;
            else if (b == ESC_ESC)
                b = ESC_BYTE;
            is_flag = 1'b0;
        end else begin
            if (b == ESC_BYTE) begin
                esc_seen = 1'b1;
                return 1'b0;
            end
            is_flag = (b == FLAG_BYTE);
        end

        case (phase)
            PH_ADDR: begin
                // Repeated opening flags are skipped here.
                if (is_flag)
                    return 1'b0;
                hdr_addr = b;
                if (cfg.address_any || b == cfg.match_address) begin
                    phase = PH_CTRL;
                    return 1'b0;
                end
                restart_frame(1'b0);
                r = frame_result(EV_HEAD_BAD, 8'h00);
                return 1'b1;
            end
            PH_CTRL: begin
                if (!is_flag) begin
                    hdr_ctrl = b;
                    if (cfg.control_any || b == cfg.match_control) begin
                        phase = PH_BCC1;
                        return 1'b0;
                    end
                end
                restart_frame(is_flag);
                r = frame_result(EV_HEAD_BAD, 8'h00);
                return 1'b1;
            end
            PH_BCC1: begin
                if (!is_flag && b == (hdr_addr ^ hdr_ctrl)) begin
                    phase = PH_HEAD_OK;
                    return 1'b0;
                end
                restart_frame(is_flag);
                r = frame_result(EV_HEAD_BAD, 8'h00);
                return 1'b1;
            end
            PH_HEAD_OK: begin
                if (is_flag) begin
                    restart_frame(1'b1);
                    r = frame_result(EV_SUPER, 8'h00);
                    return 1'b1;
                end
                pay_xor   = 8'h00;
                pay_count = '0;
                held      = b;
                held_ok   = 1'b1;
                phase     = PH_DATA;
                return 1'b0;
            end
            PH_DATA, PH_BCC2: begin
                if (phase == PH_DATA && !is_flag) begin
                    // The held byte is payload after all; the new one is
                    // now the BCC2 candidate.
                    d         = held;
                    pay_xor   = pay_xor ^ held;
                    pay_count = pay_count + 1'b1;
                    held      = b;
                    held_ok   = 1'b1;
                    if (pay_count >= MAX_PAYLOAD)
                        phase = PH_BCC2;
                    r = frame_result(EV_DATA, d);
                    return 1'b1;
                end
                if (is_flag) begin
                    r = frame_result((held_ok && held == pay_xor) ? EV_INFO_OK
                                                                  : EV_DATA_BAD, 8'h00);
                    restart_frame(1'b1);
                    return 1'b1;
                end
                // Anything but a flag after an over-long payload.
                r = frame_result(EV_DATA_BAD, 8'h00);
                restart_frame(1'b0);
                return 1'b1;
            end
            default: begin
                if (is_flag)
                    restart_frame(1'b1);
                else
                    phase = PH_HUNT;
                return 1'b0;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------

    function automatic logic [APB_DW-1:0] reg_value(input t_cfg s, input logic [1:0] idx);
        case (idx)
            REG_MATCH_ADDR: return {{(APB_DW-BYTE_W){1'b0}}, s.match_address};
            REG_ADDR_ANY:   return {{(APB_DW-1){1'b0}}, s.address_any};
            REG_MATCH_CTRL: return {{(APB_DW-BYTE_W){1'b0}}, s.match_control};
            default:        return {{(APB_DW-1){1'b0}}, s.control_any};
        endcase
    endfunction

    // Setup cycle, access cycle, then psel is dropped again so that back-to-back
    // transfers never drive psel twice in one step.
    task automatic apb_cycle(input logic is_write, input logic [1:0] idx,
                             input logic [APB_DW-1:0] wdata,
                             output logic [APB_DW-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Line side
    // ------------------------------------------------------------------

    // Offers one line byte until it is taken, then predicts what it causes.
    // Valid stays high into the next byte unless an idle burst is drawn.
    task automatic send_line(input logic [BYTE_W-1:0] raw, input logic counted);
        t_frame_result r;
        logic          fired;
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= raw;
        do @(posedge i_clk); while (!rx_ch.ready);
        fired = decode_line_byte(raw, r);
        if (typed_pending) begin
            frame_results_due.push_back(typed_want);
            typed_pending = 1'b0;
        end else if (fired) begin
            frame_results_due.push_back(r);
        end
        line_bytes++;
        if (counted)
            counted_items++;
        if (idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
            rx_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    task automatic send_stuffed(input logic [BYTE_W-1:0] d);
        if (d == FLAG_BYTE || d == ESC_BYTE) begin
            send_line(ESC_BYTE, 1'b1);
            send_line(d ^ 8'h20, 1'b1);
        end else begin
            send_line(d, 1'b1);
        end
    endtask

    // One frame with random content. Header bytes mostly match the
    // registers when matching is on, so most frames get past the header.
    task automatic send_frame(input int n_data, input t_frame_kind kind);
        logic [BYTE_W-1:0] a;
        logic [BYTE_W-1:0] c;
        logic [BYTE_W-1:0] chk;
        logic [BYTE_W-1:0] d;
        int                odd_at;
        int                k;
        if (!cfg.address_any && $urandom_range(0, 7) != 0)
            a = cfg.match_address;
        else
            a = 8'($urandom);
        if (!cfg.control_any && $urandom_range(0, 7) != 0)
            c = cfg.match_control;
        else
            c = 8'($urandom);
        odd_at = (n_data > 0) ? $urandom_range(0, n_data - 1) : -1;

        // Sometimes the previous closing flag doubles as this opening one.
        if ($urandom_range(0, 3) != 0)
            send_line(FLAG_BYTE, 1'b1);
        send_stuffed(a);
        send_stuffed(c);
        chk = a ^ c;
        if (kind == FR_BAD_BCC1)
            chk = chk ^ (8'h01 << $urandom_range(0, 7));
        send_stuffed(chk);
        if (kind == FR_SUPER) begin
            send_line(FLAG_BYTE, 1'b1);
            return;
        end

        chk = 8'h00;
        for (k = 0; k < n_data; k++) begin
            // Long payloads carry only a few flag and escape bytes, so the
            // maximum-length frames stay close to their payload size.
            if ($urandom_range(0, (n_data > 60) ? 63 : 5) == 0)
                d = $urandom_range(0, 1) ? FLAG_BYTE : ESC_BYTE;
            else
                d = 8'($urandom);
            if (kind == FR_ODD_ESCAPE && k == odd_at) begin
                // An escape before an ordinary byte leaves that byte as it is.
                do d = 8'($urandom); while (d == ESC_FLAG || d == ESC_ESC);
                send_line(ESC_BYTE, 1'b1);
                send_line(d, 1'b1);
            end else begin
                send_stuffed(d);
            end
            chk = chk ^ d;
        end
        if (kind == FR_BAD_BCC2)
            chk = chk ^ 8'($urandom_range(1, 255));
        send_stuffed(chk);
        send_line(FLAG_BYTE, 1'b1);
    endtask

    // Line noise: stray flags and escapes among random bytes. It may leave an
    // escape dangling, which turns the next flag into data.
    task automatic send_noise();
        logic [BYTE_W-1:0] b;
        repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 3))
                0:       b = FLAG_BYTE;
                1:       b = ESC_BYTE;
                default: b = 8'($urandom);
            endcase
            send_line(b, 1'b0);
        end
    endtask

    // Stops offering bytes and waits until every predicted result has been
    // taken and the pipe has had time to empty.
    task automatic drain_results();
        rx_ch.valid <= 1'b0;
        while (frame_results_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_setting(input t_cfg s);
        logic [APB_DW-1:0] rd;
        int                i;
        drain_results();
        for (i = 0; i < 4; i++)
            apb_cycle(1'b1, reg_order[i], reg_value(s, reg_order[i]), rd);
        cfg = s;
        for (i = 0; i < 4; i++) begin
            apb_cycle(1'b0, reg_order[i], '0, rd);
            if (rd !== reg_value(s, reg_order[i])) begin
                errors++;
                $display("%0t: register %0d read back: expected %0h, actual %0h",
                         $time, reg_order[i], reg_value(s, reg_order[i]), rd);
            end
        end
    endtask

    function automatic t_directed_row plain_row(input logic [BYTE_W-1:0] raw);
        t_directed_row row;
        row.raw     = raw;
        row.checked = 1'b0;
        row.want    = '0;
        return row;
    endfunction

    function automatic t_directed_row typed_row(input logic [BYTE_W-1:0] raw,
                                                input logic [EV_W-1:0] ev,
                                                input logic [BYTE_W-1:0] d,
                                                input logic [BYTE_W-1:0] a,
                                                input logic [BYTE_W-1:0] c,
                                                input logic [LEN_W-1:0] n);
        t_directed_row row;
        row.raw     = raw;
        row.checked = 1'b1;
        row.want    = '{ev, d, a, c, n};
        return row;
    endfunction

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    task automatic check_field(input string what, input int unsigned want_v,
                               input int unsigned got_v);
        if (want_v != got_v) begin
            errors++;
            $display("%0t: %s: expected %0h, actual %0h", $time, what, want_v, got_v);
        end
    endtask

    // Takes result beats, compares each with the oldest prediction, and
    // draws the ready pattern: short random stalls, and on request one long
    // hold-off so that the block fills and pushes back on the line side.
    initial begin : result_sink
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_ch.valid && res_ch.ready) begin
                got = '{res_ch.event_res, res_ch.data_byte, res_ch.frame_address,
                        res_ch.frame_control, res_ch.data_length};
                if (frame_results_due.size() == 0) begin
                    errors++;
                    $display("%0t: result beat with none expected: expected nothing, actual %0h",
                             $time, got);
                end else begin
                    want = frame_results_due.pop_front();
                    if (want.ev_code <= EV_DATA_BAD)
                        ev_tally[want.ev_code]++;
                    check_field("event", want.ev_code, got.ev_code);
                    check_field("data byte", want.data, got.data);
                    check_field("frame address", want.address, got.address);
                    check_field("frame control", want.control, got.control);
                    check_field("data length", want.length, got.length);
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else if (holds_done != hold_requests) begin
                holds_done++;
                hold_left = HOLD_OFF_CYCLES - 1;
                res_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end else if (idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
                stall_left = $urandom_range(0, 11);
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    initial begin : watchdog
        while (cycle_count <= CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
        $display("tb_stuffed_frame_receiver NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_cfg          settings[6];
        int            phase_odds[6];
        int            p;
        int            phase_start;
        int            r;
        logic          paused;
        t_frame_kind   kind;
        t_directed_row row;

        paused        = 1'b0;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= 8'h00;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        i_rst_n       <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, run with the reset settings (any address, any
        // control). Rows with a typed result are ones whose outcome is plain
        // from the frame itself; the rest go through the decoder.
        directed_rows.push_back(plain_row(FLAG_BYTE));     // opening flag
        directed_rows.push_back(plain_row(FLAG_BYTE));     // repeated flag skipped
        directed_rows.push_back(plain_row(8'hFF));         // address at its top value
        directed_rows.push_back(plain_row(8'h00));         // control at its bottom value
        directed_rows.push_back(plain_row(8'hFF));         // BCC1
        // A flag straight after BCC1 ends a supervisory frame.
        directed_rows.push_back(typed_row(FLAG_BYTE, EV_SUPER, 8'h00, 8'hFF, 8'h00, 10'd0));
        directed_rows.push_back(plain_row(8'h03));
        directed_rows.push_back(plain_row(8'h08));
        directed_rows.push_back(plain_row(8'h0B));
        // An escaped flag is data, never a flag.
        directed_rows.push_back(plain_row(ESC_BYTE));
        directed_rows.push_back(plain_row(ESC_FLAG));
        // Escaped escape; the escaped flag comes out one byte late.
        directed_rows.push_back(plain_row(ESC_BYTE));
        directed_rows.push_back(typed_row(ESC_ESC, EV_DATA, FLAG_BYTE, 8'h03, 8'h08, 10'd1));
        // An escape before an ordinary byte leaves it unchanged.
        directed_rows.push_back(plain_row(ESC_BYTE));
        directed_rows.push_back(plain_row(8'h31));
        directed_rows.push_back(plain_row(8'h32));         // BCC2 = 7E ^ 7D ^ 31
        directed_rows.push_back(typed_row(FLAG_BYTE, EV_INFO_OK, 8'h00, 8'h03, 8'h08, 10'd3));
        // Wrong BCC1 on an ordinary byte: back to hunting.
        directed_rows.push_back(plain_row(8'h01));
        directed_rows.push_back(plain_row(8'h02));
        directed_rows.push_back(typed_row(8'h00, EV_HEAD_BAD, 8'h00, 8'h01, 8'h02, 10'd0));
        directed_rows.push_back(plain_row(FLAG_BYTE));
        // Flag in the control slot: header error, and the flag opens again.
        directed_rows.push_back(plain_row(8'h10));
        directed_rows.push_back(typed_row(FLAG_BYTE, EV_HEAD_BAD, 8'h00, 8'h10, 8'h02, 10'd0));
        // One byte after the header, then a flag: that byte is a bad BCC2.
        directed_rows.push_back(plain_row(8'h20));
        directed_rows.push_back(plain_row(8'h30));
        directed_rows.push_back(plain_row(8'h10));
        directed_rows.push_back(plain_row(8'h55));
        directed_rows.push_back(typed_row(FLAG_BYTE, EV_DATA_BAD, 8'h00, 8'h20, 8'h30, 10'd0));

        idle_odds = 4;
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.checked) begin
                typed_want    = row.want;
                typed_pending = 1'b1;
            end
            send_line(row.raw, 1'b1);
        end

        // Longest legal payload, then one byte too many, which turns the
        // BCC2 slot into a data error.
        send_frame(MAX_PAYLOAD, FR_CLEAN);
        send_frame(MAX_PAYLOAD + 1, FR_CLEAN);

        // Register settings for the random phases: the reset values first,
        // then strict matching at the extremes, the special line bytes as
        // match values, a random draw, and finally back to any/any. The last
        // phase runs without idling on either side.
        settings[0] = cfg;
        settings[1] = '{8'h00, 1'b0, 8'hFF, 1'b0};
        settings[2] = '{8'hFF, 1'b0, 8'h00, 1'b1};
        settings[3] = '{FLAG_BYTE, 1'b1, ESC_BYTE, 1'b0};
        settings[4].match_address = 8'($urandom);
        settings[4].address_any   = 1'($urandom_range(0, 1));
        settings[4].match_control = 8'($urandom);
        settings[4].control_any   = 1'($urandom_range(0, 1));
        settings[5] = '{8'h00, 1'b1, 8'h00, 1'b1};
        phase_odds  = '{6, 3, 10, 2, 5, 0};

        for (p = 0; p < 6; p++) begin
            if (p > 0)
                apply_setting(settings[p]);
            idle_odds   = phase_odds[p];
            phase_start = counted_items;
            while (counted_items - phase_start < PHASE_ITEMS) begin
                // One long hold-off on the result side in the third phase,
                // while the line side keeps offering bytes.
                if (p == 2 && hold_requests == 0 && counted_items - phase_start > 12)
                    hold_requests++;
                // In the fourth phase the line side pauses once until
                // everything predicted has come out.
                if (p == 3 && !paused && counted_items - phase_start > 20) begin
                    drain_results();
                    paused = 1'b1;
                end
                r = $urandom_range(0, 99);
                if (r < 5) begin
                    send_noise();
                end else begin
                    if (r < 13)
                        kind = FR_SUPER;
                    else if (r < 20)
                        kind = FR_BAD_BCC1;
                    else if (r < 28)
                        kind = FR_BAD_BCC2;
                    else if (r < 34)
                        kind = FR_ODD_ESCAPE;
                    else
                        kind = FR_CLEAN;
                    if ($urandom_range(0, 7) == 0)
                        send_frame($urandom_range(13, 60), kind);
                    else
                        send_frame($urandom_range(0, 12), kind);
                end
            end
        end

        drain_results();
        $display("Sent %0d line bytes over six register settings, with maximum-length %s",
                 line_bytes, "payloads, a long result hold-off and a full drain.");
        $display("Checked %0d payload bytes, %0d supervisory, %0d good, %0d header-error %s",
                 ev_tally[EV_DATA], ev_tally[EV_SUPER], ev_tally[EV_INFO_OK],
                 ev_tally[EV_HEAD_BAD], $sformatf("and %0d data-error results.",
                 ev_tally[EV_DATA_BAD]));
        if (errors == 0 && frame_results_due.size() == 0)
            $display("tb_stuffed_frame_receiver OK");
        else
            $display("tb_stuffed_frame_receiver NOT OK");
        $finish;
    end

endmodule
